// File: hw/rtl/rmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_pkg: shared types and constants of the region mosaic block
// Payload structs, register indexes, operation codes and field widths.
// ----------------------------------------------------------------------------
package rmp_pkg;

    localparam int POS_W     = 9;   // column / row field width
    localparam int EXT_W     = 10;  // region extent width
    localparam int CELL_W    = 7;   // cell size width
    localparam int COORD_W   = 10;  // cell edge / centre coordinate width
    localparam int CFG_W     = 10;  // config data width (widest register)
    localparam int CFG_IDX_W = 2;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;

    localparam int MAX_COLS_DEF = 512;
    localparam int MAX_ROWS_DEF = 512;

    localparam logic [EXT_W-1:0]  REGION_RESET = 10'd512;
    localparam logic [CELL_W-1:0] CELL_RESET   = 7'd18;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H   = 2'd3;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // makeup of the delay from an accepted read to its result strobe:
    // one divider step per position bit, then multiply, address, read, output
    localparam int RD_LATENCY = POS_W + 4;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic [CH_W-1:0]   blue_in;
        logic [CH_W-1:0]   green_in;
        logic [CH_W-1:0]   red_in;
    } t_in;

    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
        logic            covered;
    } t_out;

    typedef struct packed {
        logic load;   // latch position and start a new division
        logic step;   // one restoring division step
        logic eval;   // register the rounded-up edge
    } t_axis_ctrl;

endpackage

// File: hw/rtl/rmp_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_axis: cell edge search along one axis
// Bit-serial restoring divide of a position by the cell size, then the
// winning cell edge and its centre.
// ----------------------------------------------------------------------------
module rmp_axis
    import rmp_pkg::*;
(
    input  logic               i_clk,
    input  t_axis_ctrl         i_ctrl,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [CELL_W-1:0]  i_cell,
    input  logic [EXT_W-1:0]   i_extent,
    output logic               o_covered,
    output logic [COORD_W-1:0] o_centre
);

    localparam int UP_W = COORD_W + CELL_W;

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_quo;
    logic [CELL_W-1:0] r_rem;
    logic [UP_W-1:0]   r_up;

    logic [CELL_W:0]   rem_sh;
    logic              take;
    logic              cell_ok;
    logic              up_in;
    logic              on_edge;
    logic [COORD_W-1:0] edge_pos;

    assign rem_sh = {r_rem, r_quo[POS_W-1]};
    assign take   = rem_sh >= {1'b0, i_cell};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_pos <= i_pos;
            r_quo <= i_pos;
            r_rem <= '0;
        end else if (i_ctrl.step) begin
            r_quo <= {r_quo[POS_W-2:0], take};
            r_rem <= take ? CELL_W'(rem_sh - {1'b0, i_cell}) : rem_sh[CELL_W-1:0];
        end
        if (i_ctrl.eval) begin
            r_up <= (UP_W'(r_quo) + UP_W'(1)) * UP_W'(i_cell);
        end
    end

    assign cell_ok  = (i_cell != '0) && (EXT_W'(r_pos) < i_extent);
    assign up_in    = r_up < UP_W'(i_extent);
    assign on_edge  = (r_pos >= POS_W'(i_cell)) && (r_rem == '0);
    assign edge_pos = up_in ? r_up[COORD_W-1:0] : COORD_W'(r_pos);

    assign o_covered = cell_ok && (up_in || on_edge);
    assign o_centre  = edge_pos - COORD_W'(i_cell[CELL_W-1:1]);

endmodule

// File: hw/rtl/region_mosaic_pixelation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_mosaic_pixelation: privacy mosaic over a stored BGR frame
// Writes load pixels into a frame store; reads return the mosaicked pixel,
// taken from the centre of the covering cell or passed through.
// ----------------------------------------------------------------------------
//  channel   signals                              transaction on
//  --------  -----------------------------------  --------------------------
//  input     start, busy, i_in (t_in)             start && !busy
//  result    o_valid, o_result (t_out)            o_valid (one cycle)
//  config    i_cfg_we, i_cfg_idx, i_cfg_data      i_cfg_we
//
//  A write goes into the store at its accept edge and busy stays low. A
//  read keeps busy high, so no new transaction is accepted, while it passes
//  through the bit-serial divider (one step per position bit, 9 steps),
//  the edge multiply, the address multiply, the registered store read and
//  the output state, in which the result strobe is raised.
//  Reset clears the control state and the configuration registers; the
//  frame store has no clearing pass and holds garbage until written. The
//  receiver cannot stall.
// ----------------------------------------------------------------------------
module region_mosaic_pixelation
    import rmp_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in                  i_in,
    output logic                 o_valid,
    output t_out                 o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(POS_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // configuration registers
    logic [EXT_W-1:0]  r_region_w;
    logic [EXT_W-1:0]  r_region_h;
    logic [CELL_W-1:0] r_cell_w;
    logic [CELL_W-1:0] r_cell_h;

    // control
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // payload
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic [AW-1:0]    r_addr;
    logic             r_inrange;
    logic             r_cov;
    logic [PIX_W-1:0] r_rdata;

    logic [PIX_W-1:0] mem_frame [DEPTH];

    logic               accept;
    logic               wr_en;
    t_axis_ctrl         axis_ctrl;
    logic               cov_x, cov_y;
    logic [COORD_W-1:0] cen_x, cen_y;
    logic [COORD_W-1:0] sel_col, sel_row;
    logic [AW-1:0]      wr_addr, rd_addr;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_w <= REGION_RESET;
            r_region_h <= REGION_RESET;
            r_cell_w   <= CELL_RESET;
            r_cell_h   <= CELL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REGION_W: r_region_w <= i_cfg_data[EXT_W-1:0];
                REG_REGION_H: r_region_h <= i_cfg_data[EXT_W-1:0];
                REG_CELL_W:   r_cell_w   <= i_cfg_data[CELL_W-1:0];
                REG_CELL_H:   r_cell_h   <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    // Walk a read through divide, multiply, address, store read and output.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.op == OP_READ) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(POS_W - 1)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ADDR;
            ST_ADDR: n_state = ST_READ;
            ST_READ: n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // ---------------- cell search per axis ----------------
    assign axis_ctrl.load = accept && i_in.op == OP_READ;
    assign axis_ctrl.step = (r_state == ST_DIV);
    assign axis_ctrl.eval = (r_state == ST_MUL);

    rmp_axis u_axis_x (
        .i_clk     (i_clk),
        .i_ctrl    (axis_ctrl),
        .i_pos     (i_in.column),
        .i_cell    (r_cell_w),
        .i_extent  (r_region_w),
        .o_covered (cov_x),
        .o_centre  (cen_x)
    );

    rmp_axis u_axis_y (
        .i_clk     (i_clk),
        .i_ctrl    (axis_ctrl),
        .i_pos     (i_in.row),
        .i_cell    (r_cell_h),
        .i_extent  (r_region_h),
        .o_covered (cov_y),
        .o_centre  (cen_y)
    );

    // ---------------- address ----------------
    // A pixel is replaced only when both axes find a covering cell.
    assign sel_col = (cov_x && cov_y) ? cen_x : COORD_W'(r_col);
    assign sel_row = (cov_x && cov_y) ? cen_y : COORD_W'(r_row);

    assign wr_en   = accept && (i_in.op == OP_WRITE) &&
                     (int'(i_in.column) < MAX_COLS) && (int'(i_in.row) < MAX_ROWS);
    assign wr_addr = AW'(RW'(i_in.row)) * AW'(MAX_COLS) + AW'(CW'(i_in.column));

    always_ff @(posedge i_clk) begin
        if (axis_ctrl.load) begin
            r_col <= i_in.column;
            r_row <= i_in.row;
        end
        if (r_state == ST_ADDR) begin
            r_addr    <= AW'(RW'(sel_row)) * AW'(MAX_COLS) + AW'(CW'(sel_col));
            // centres or positions past the store read as zero
            r_inrange <= (int'(sel_col) < MAX_COLS) && (int'(sel_row) < MAX_ROWS);
            r_cov     <= cov_x && cov_y;
        end
    end

    // ---------------- frame store ----------------
    // Single port: writes happen only while idle; the store is read every cycle, and the read state's read is used.
    assign rd_addr = busy ? r_addr : wr_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_frame[rd_addr] <= {i_in.red_in, i_in.green_in, i_in.blue_in};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem_frame[rd_addr];
    end

    // ---------------- result ----------------
    assign o_valid            = (r_state == ST_OUT);
    assign o_result.blue_out  = r_inrange ? r_rdata[CH_W-1:0]        : '0;
    assign o_result.green_out = r_inrange ? r_rdata[2*CH_W-1:CH_W]   : '0;
    assign o_result.red_out   = r_inrange ? r_rdata[3*CH_W-1:2*CH_W] : '0;
    assign o_result.covered   = r_cov;

endmodule

// File: hw/rtl/rmp_sva.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_sva: port-level checks of the region mosaic block
// Strobe timing, busy behavior and configuration timing at the ports.
// ----------------------------------------------------------------------------
module rmp_sva
    import rmp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_in,
    input logic o_valid,
    input t_out o_result,
    input logic i_cfg_we
);

    logic rd_acc, wr_acc;
    assign rd_acc = start && !busy && (i_in.op == OP_READ);
    assign wr_acc = start && !busy && (i_in.op == OP_WRITE);

    // a result shows only while a read transaction is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // a write finishes at its accept edge
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_acc |=> !busy && !o_valid)
        else $error("write left the block busy");

    // every accepted read raises its result strobe with a known covered flag
    a_read_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |-> ##RD_LATENCY (o_valid && !$isunknown(o_result.covered)))
        else $error("read result missing or late");

    // busy drops right after the result cycle
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("block held after result");

    // the user writes registers only while idle; the block does not enforce it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !busy)
        else $error("register write during a read");

endmodule

bind region_mosaic_pixelation rmp_sva u_rmp_sva (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_valid  (o_valid),
    .o_result (o_result),
    .i_cfg_we (i_cfg_we)
);
